FILE: src/tcs_pkg.sv
`timescale 1ns / 1ps

package tcs_pkg;

    // Largest value the semaphore count may reach.
    localparam logic signed [15:0] COUNT_MAX = 16'sd32767;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] MODE_WAIT   = 2'd0;
    localparam logic [1:0] MODE_SIGNAL = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_GRANTED   = 3'd0,
        STAT_BLOCKED   = 3'd1,
        STAT_WOKEN     = 3'd2,
        STAT_TIMEOUT   = 3'd3,
        STAT_NO_WAITER = 3'd4,
        STAT_REJECTED  = 3'd5
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SIG_FIFO,
        ST_SIG_POP,
        ST_SIG_ADD,
        ST_WK_RD,
        ST_WK_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_INS_WR,
        ST_TK_RD,
        ST_TK_CMP,
        ST_FLUSH
    } state_t;

    // One sleep list entry: thread and delta to its predecessor.
    typedef struct packed {
        logic [7:0]  thread;
        logic [15:0] delta;
    } sleep_entry_t;

    // One result word.
    typedef struct packed {
        status_t            status;
        logic [7:0]         thread;
        logic               rv;
        logic signed [15:0] count;
    } result_t;

endpackage

FILE: src/timed_counting_semaphore.sv
`timescale 1ns / 1ps

// Timed counting semaphore.
// Input words arrive on s_tvalid/s_tready: s_tuser holds the operation
// (wait, signal, elapsed ticks), s_tdata the thread, timeout and tick count.
// Result words leave on m_tvalid/m_tready, m_tlast marking the final result
// of an input word. The count is loaded from the cfg channel, which also
// empties both waiter queues; it is written only while the block is idle,
// and a pending write holds off the input for that cycle.
// One input word is worked at a time. A timed wait walks the sleep list
// memory, reading each entry it passes and moving up each entry it shifts.
// A tick removes each expiring head sleeper and shortens the delta of the
// one left at the head. Sleep list and unlimited waiters live in
// single-port-read memories with a registered read, and that walk sets the
// rate. A one-word output register and a one-result hold stage sit before
// m_tdata; when the receiver stalls the sequencer waits there and no input
// is taken. After reset the count is 0 and both queues are empty; there is
// no clearing pass.
module timed_counting_semaphore
    import tcs_pkg::*;
#(
    parameter int FIFO_DEPTH  = 16,
    parameter int SLEEP_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // mode
    input  logic [31:0] s_tdata,   // thread_id[7:0], max_wait[23:8], tick_count[31:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // status
    output logic [31:0] m_tdata,   // thread_id_res[7:0], return_value[8], count[24:9], zeros
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data   // initial_count
);

    localparam int FAW = FIFO_DEPTH > 1 ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCW = $clog2(FIFO_DEPTH + 1);
    localparam int SAW = SLEEP_DEPTH > 1 ? $clog2(SLEEP_DEPTH) : 1;
    localparam int SCW = $clog2(SLEEP_DEPTH + 1);

    state_t             st_reg, st_next;
    logic [1:0]         mode_reg, mode_next;
    logic [7:0]         tid_reg, tid_next;
    logic [15:0]        wait_reg, wait_next;
    logic [7:0]         tick_reg, tick_next;
    logic signed [15:0] cnt_reg, cnt_next;
    logic [FAW-1:0]     fh_reg, fh_next;
    logic [FCW-1:0]     fu_reg, fu_next;
    logic [SAW-1:0]     sh_reg, sh_next;
    logic [SCW-1:0]     su_reg, su_next;
    logic [15:0]        rem_reg, rem_next;
    logic [SCW-1:0]     idx_reg, idx_next;
    logic [SCW-1:0]     pos_reg, pos_next;
    logic [15:0]        mod_reg, mod_next;
    logic [15:0]        d_reg, d_next;
    logic               pend_valid_reg, pend_valid_next;
    result_t            pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;
    logic               out_last_reg, out_last_next;

    logic               f_wr_en, f_rd_en;
    logic [FAW-1:0]     f_wr_addr;
    logic [7:0]         f_rd_data;
    logic               s_wr_en, s_rd_en;
    logic [SAW-1:0]     s_wr_addr, s_rd_addr;
    sleep_entry_t       s_wr_data, s_rd_data;

    logic               emit_en, flush_en;
    result_t            emit_res;
    logic               out_free, can_emit;
    logic [FAW:0]       tail_sum;
    logic [FAW-1:0]     fifo_tail;
    logic [FAW-1:0]     fh_inc;
    logic [SAW-1:0]     sh_inc;
    logic signed [15:0] cnt_sat;
    logic [15:0]        waiters;

    // Physical slot of a logical sleep list position.
    function automatic logic [SAW-1:0] sphys(input logic [SAW-1:0] head,
                                             input logic [SCW-1:0] x);
        logic [SAW:0] sum;
        sum = {1'b0, head} + (SAW+1)'(x);
        if (sum >= (SAW+1)'(SLEEP_DEPTH))
        begin
            sum = sum - (SAW+1)'(SLEEP_DEPTH);
        end
        return sum[SAW-1:0];
    endfunction

    // Queue memories.
    tcs_ram #(.DW(8), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
        .clk     (clk),
        .wr_en   (f_wr_en),
        .wr_addr (f_wr_addr),
        .wr_data (tid_reg),
        .rd_en   (f_rd_en),
        .rd_addr (fh_reg),
        .rd_data (f_rd_data)
    );

    tcs_ram #(.DW($bits(sleep_entry_t)), .DEPTH(SLEEP_DEPTH)) u_sleep_ram (
        .clk     (clk),
        .wr_en   (s_wr_en),
        .wr_addr (s_wr_addr),
        .wr_data (s_wr_data),
        .rd_en   (s_rd_en),
        .rd_addr (s_rd_addr),
        .rd_data (s_rd_data)
    );

    // Helpers shared by several states.
    assign out_free  = !out_valid_reg || m_tready;
    assign can_emit  = !pend_valid_reg || out_free;
    assign tail_sum  = {1'b0, fh_reg} + (FAW+1)'(fu_reg);
    assign fifo_tail = (tail_sum >= (FAW+1)'(FIFO_DEPTH)) ?
                       FAW'(tail_sum - (FAW+1)'(FIFO_DEPTH)) : tail_sum[FAW-1:0];
    assign fh_inc    = (fh_reg == FAW'(FIFO_DEPTH - 1)) ? '0 : fh_reg + 1'b1;
    assign sh_inc    = (sh_reg == SAW'(SLEEP_DEPTH - 1)) ? '0 : sh_reg + 1'b1;
    assign cnt_sat   = (cnt_reg < COUNT_MAX) ? cnt_reg + 16'sd1 : cnt_reg;
    assign waiters   = 16'(fu_reg) + 16'(su_reg);

    // Handshake outputs; a configuration write takes precedence over input.
    assign s_tready  = (st_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (st_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_reg.status;
    assign m_tdata   = {7'd0, out_reg.count, out_reg.rv, out_reg.thread};
    assign m_tlast   = out_last_reg;

    // Sequencer: next state, memory accesses and results.
    always_comb
    begin
        st_next         = st_reg;
        mode_next       = mode_reg;
        tid_next        = tid_reg;
        wait_next       = wait_reg;
        tick_next       = tick_reg;
        cnt_next        = cnt_reg;
        fh_next         = fh_reg;
        fu_next         = fu_reg;
        sh_next         = sh_reg;
        su_next         = su_reg;
        rem_next        = rem_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        mod_next        = mod_reg;
        d_next          = d_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        f_wr_en         = 1'b0;
        f_wr_addr       = fifo_tail;
        f_rd_en         = 1'b0;
        s_wr_en         = 1'b0;
        s_wr_addr       = sphys(sh_reg, '0);
        s_wr_data       = s_rd_data;
        s_rd_en         = 1'b0;
        s_rd_addr       = sphys(sh_reg, '0);
        emit_en         = 1'b0;
        flush_en        = 1'b0;
        emit_res        = '{status: STAT_GRANTED, thread: tid_reg, rv: 1'b0,
                            count: cnt_reg};

        unique case (st_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    cnt_next = 16'(cfg_data);
                    fh_next  = '0;
                    fu_next  = '0;
                    sh_next  = '0;
                    su_next  = '0;
                end
                else if (s_tvalid)
                begin
                    mode_next = s_tuser;
                    tid_next  = s_tdata[7:0];
                    wait_next = s_tdata[23:8];
                    tick_next = s_tdata[31:24];
                    st_next   = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                st_next = ST_FLUSH;
                if (mode_reg == MODE_WAIT)
                begin
                    emit_en = 1'b1;
                    if (cnt_reg > 16'sd0)
                    begin
                        cnt_next          = cnt_reg - 16'sd1;
                        emit_res.status   = STAT_GRANTED;
                        emit_res.rv       = 1'b1;
                        emit_res.count    = cnt_reg - 16'sd1;
                    end
                    else if (wait_reg == 16'd0)
                    begin
                        if (fu_reg == FCW'(FIFO_DEPTH))
                        begin
                            emit_res.status = STAT_REJECTED;
                        end
                        else
                        begin
                            f_wr_en         = 1'b1;
                            fu_next         = fu_reg + 1'b1;
                            cnt_next        = cnt_reg - 16'sd1;
                            emit_res.status = STAT_BLOCKED;
                            emit_res.count  = cnt_reg - 16'sd1;
                        end
                    end
                    else if (su_reg == SCW'(SLEEP_DEPTH))
                    begin
                        emit_res.status = STAT_REJECTED;
                    end
                    else
                    begin
                        // Sorted insert: walk the list first.
                        emit_en  = 1'b0;
                        rem_next = wait_reg;
                        idx_next = '0;
                        st_next  = ST_WK_RD;
                    end
                end
                else if (mode_reg == MODE_SIGNAL)
                begin
                    if (cnt_reg < 16'sd0 && fu_reg != '0)
                    begin
                        f_rd_en = 1'b1;
                        st_next = ST_SIG_FIFO;
                    end
                    else if (cnt_reg < 16'sd0 && su_reg != '0)
                    begin
                        s_rd_en = 1'b1;
                        st_next = ST_SIG_POP;
                    end
                    else
                    begin
                        cnt_next        = cnt_sat;
                        emit_en         = 1'b1;
                        emit_res.status = STAT_NO_WAITER;
                        emit_res.thread = 8'd0;
                        emit_res.count  = cnt_sat;
                    end
                end
                else if (mode_reg == MODE_TICK)
                begin
                    rem_next = 16'(tick_reg);
                    st_next  = ST_TK_RD;
                end
            end

            ST_SIG_FIFO:
            begin
                fh_next         = fh_inc;
                fu_next         = fu_reg - 1'b1;
                cnt_next        = cnt_reg + 16'sd1;
                emit_en         = 1'b1;
                emit_res.status = STAT_WOKEN;
                emit_res.thread = f_rd_data;
                emit_res.rv     = 1'b1;
                emit_res.count  = cnt_reg + 16'sd1;
                st_next         = ST_FLUSH;
            end

            ST_SIG_POP:
            begin
                // Head sleeper leaves; its delta goes to the successor.
                d_next          = s_rd_data.delta;
                sh_next         = sh_inc;
                su_next         = su_reg - 1'b1;
                cnt_next        = cnt_reg + 16'sd1;
                emit_en         = 1'b1;
                emit_res.status = STAT_WOKEN;
                emit_res.thread = s_rd_data.thread;
                emit_res.rv     = 1'b1;
                emit_res.count  = cnt_reg + 16'sd1;
                if (su_reg > SCW'(1))
                begin
                    s_rd_en   = 1'b1;
                    s_rd_addr = sh_inc;
                    st_next   = ST_SIG_ADD;
                end
                else
                begin
                    st_next = ST_FLUSH;
                end
            end

            ST_SIG_ADD:
            begin
                s_wr_en         = 1'b1;
                s_wr_addr       = sh_reg;
                s_wr_data.delta = s_rd_data.delta + d_reg;
                st_next         = ST_FLUSH;
            end

            ST_WK_RD:
            begin
                if (idx_reg == su_reg)
                begin
                    pos_next = su_reg;
                    st_next  = ST_INS_WR;
                end
                else
                begin
                    s_rd_en   = 1'b1;
                    s_rd_addr = sphys(sh_reg, idx_reg);
                    st_next   = ST_WK_CMP;
                end
            end

            ST_WK_CMP:
            begin
                if (rem_reg < s_rd_data.delta)
                begin
                    pos_next = idx_reg;
                    mod_next = s_rd_data.delta - rem_reg;
                    idx_next = su_reg;
                    st_next  = ST_SH_RD;
                end
                else
                begin
                    rem_next = rem_reg - s_rd_data.delta;
                    idx_next = idx_reg + 1'b1;
                    st_next  = ST_WK_RD;
                end
            end

            ST_SH_RD:
            begin
                s_rd_en   = 1'b1;
                s_rd_addr = sphys(sh_reg, idx_reg - 1'b1);
                st_next   = ST_SH_WR;
            end

            ST_SH_WR:
            begin
                // Move one entry up; the one displaced by the new sleeper
                // carries its shortened delta.
                s_wr_en   = 1'b1;
                s_wr_addr = sphys(sh_reg, idx_reg);
                if (idx_reg - 1'b1 == pos_reg)
                begin
                    s_wr_data.delta = mod_reg;
                    st_next         = ST_INS_WR;
                end
                else
                begin
                    st_next = ST_SH_RD;
                end
                idx_next = idx_reg - 1'b1;
            end

            ST_INS_WR:
            begin
                s_wr_en          = 1'b1;
                s_wr_addr        = sphys(sh_reg, pos_reg);
                s_wr_data.thread = tid_reg;
                s_wr_data.delta  = rem_reg;
                su_next          = su_reg + 1'b1;
                cnt_next         = cnt_reg - 16'sd1;
                emit_en          = 1'b1;
                emit_res.status  = STAT_BLOCKED;
                emit_res.count   = cnt_reg - 16'sd1;
                st_next          = ST_FLUSH;
            end

            ST_TK_RD:
            begin
                if (su_reg == '0)
                begin
                    st_next = ST_FLUSH;
                end
                else
                begin
                    s_rd_en = 1'b1;
                    st_next = ST_TK_CMP;
                end
            end

            ST_TK_CMP:
            begin
                if (s_rd_data.delta <= rem_reg)
                begin
                    // Expiry; waits here while the output is full.
                    if (can_emit)
                    begin
                        rem_next        = rem_reg - s_rd_data.delta;
                        sh_next         = sh_inc;
                        su_next         = su_reg - 1'b1;
                        cnt_next        = cnt_sat;
                        emit_en         = 1'b1;
                        emit_res.status = STAT_TIMEOUT;
                        emit_res.thread = s_rd_data.thread;
                        emit_res.count  = cnt_sat;
                        st_next         = ST_TK_RD;
                    end
                end
                else
                begin
                    if (rem_reg != 16'd0)
                    begin
                        s_wr_en         = 1'b1;
                        s_wr_data.delta = s_rd_data.delta - rem_reg;
                    end
                    st_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    st_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    flush_en = 1'b1;
                    st_next  = ST_IDLE;
                end
            end

            default:
            begin
                st_next = ST_IDLE;
            end
        endcase

        // Results pass through the hold stage so the last one can be marked.
        if (emit_en)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = emit_res;
            pend_valid_next = 1'b1;
        end
        else if (flush_en)
        begin
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_IDLE;
            cnt_reg        <= '0;
            fh_reg         <= '0;
            fu_reg         <= '0;
            sh_reg         <= '0;
            su_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            cnt_reg        <= cnt_next;
            fh_reg         <= fh_next;
            fu_reg         <= fu_next;
            sh_reg         <= sh_next;
            su_reg         <= su_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        tid_reg      <= tid_next;
        wait_reg     <= wait_next;
        tick_reg     <= tick_next;
        rem_reg      <= rem_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        mod_reg      <= mod_next;
        d_reg        <= d_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // While waiters are queued the count is minus their number.
    a_count_tracks_waiters: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_IDLE && waiters != 16'd0) |-> (cnt_reg + $signed(waiters) == 16'sd0))
        else $error("count does not match queued waiters");

    // A held result exists only while results are still being produced.
    a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (st_reg == ST_TK_RD || st_reg == ST_TK_CMP
                            || st_reg == ST_SIG_ADD || st_reg == ST_FLUSH))
        else $error("held result outside result phase");

    // Queue fill counts stay within their memories.
    a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (fu_reg <= FCW'(FIFO_DEPTH)) && (su_reg <= SCW'(SLEEP_DEPTH)))
        else $error("queue fill count out of range");

endmodule

FILE: src/tcs_ram.sv
`timescale 1ns / 1ps

module tcs_ram
#(
    parameter int DW    = 8,
    parameter int DEPTH = 16
)
(
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [DW-1:0]                            wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [DW-1:0]                            rd_data
);

    logic [DW-1:0] mem [DEPTH];

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: tb/sv/tb_timed_counting_semaphore.sv
`timescale 1ns / 1ps

module tb_timed_counting_semaphore;
    import tcs_pkg::*;

    localparam int FIFO_CAP  = 16;
    localparam int SLEEP_CAP = 16;
    localparam int COUNT_TOP = 32767;

    // Operation code with no function; the block ignores it.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct {
        status_t     status;
        logic [7:0]  thread;
        logic        rv;
        logic [15:0] count;
        logic        last;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [2:0]  m_tuser;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [14:0] cfg_data = '0;

    // Predictor state of the semaphore.
    int          sem_level;
    logic [7:0]  fifo_ids[$];
    logic [7:0]  sleeper_ids[$];
    int          sleeper_deltas[$];
    outcome_t    pending_outcomes[$];
    int          error_count = 0;
    bit          hold_off = 1'b0;
    bit          quiet_run = 1'b0;

    always #6 clk = ~clk;

    timed_counting_semaphore #(.FIFO_DEPTH(FIFO_CAP), .SLEEP_DEPTH(SLEEP_CAP)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    function automatic void push_outcome(status_t st, logic [7:0] tid, logic rv);
        outcome_t o;
        o.status = st;
        o.thread = tid;
        o.rv     = rv;
        o.count  = 16'(sem_level);
        o.last   = 1'b0;
        pending_outcomes.insert(pending_outcomes.size(), o);
    endfunction

    function automatic logic [7:0] pop_head_sleeper();
        logic [7:0] tid;
        int d;
        tid = sleeper_ids.pop_front();
        d = sleeper_deltas.pop_front();
        if (sleeper_deltas.size() > 0)
            sleeper_deltas[0] = (sleeper_deltas[0] + d) & 16'hFFFF;
        return tid;
    endfunction

    function automatic void add_sleeper(logic [7:0] tid, int timeout);
        int rem;
        int pos;
        rem = timeout;
        pos = sleeper_ids.size();
        for (int i = 0; i < sleeper_ids.size(); i++)
        begin
            if (rem < sleeper_deltas[i])
            begin
                sleeper_deltas[i] -= rem;
                pos = i;
                break;
            end
            rem -= sleeper_deltas[i];
        end
        sleeper_ids.insert(pos, tid);
        sleeper_deltas.insert(pos, rem);
    endfunction

    // Work out the results of one operation and queue them.
    function automatic void predict_operation(logic [1:0] mode, logic [7:0] tid,
                                              logic [15:0] timeout, logic [7:0] ticks);
        int before_size;
        int rem;
        before_size = pending_outcomes.size();
        if (mode == MODE_WAIT)
        begin
            if (sem_level > 0)
            begin
                sem_level--;
                push_outcome(STAT_GRANTED, tid, 1'b1);
            end
            else if (timeout == 0)
            begin
                if (fifo_ids.size() >= FIFO_CAP)
                    push_outcome(STAT_REJECTED, tid, 1'b0);
                else
                begin
                    fifo_ids.insert(fifo_ids.size(), tid);
                    sem_level--;
                    push_outcome(STAT_BLOCKED, tid, 1'b0);
                end
            end
            else if (sleeper_ids.size() >= SLEEP_CAP)
                push_outcome(STAT_REJECTED, tid, 1'b0);
            else
            begin
                add_sleeper(tid, timeout);
                sem_level--;
                push_outcome(STAT_BLOCKED, tid, 1'b0);
            end
        end
        else if (mode == MODE_SIGNAL)
        begin
            if (sem_level < 0 && fifo_ids.size() > 0)
            begin
                sem_level++;
                push_outcome(STAT_WOKEN, fifo_ids.pop_front(), 1'b1);
            end
            else if (sem_level < 0 && sleeper_ids.size() > 0)
            begin
                sem_level++;
                push_outcome(STAT_WOKEN, pop_head_sleeper(), 1'b1);
            end
            else
            begin
                if (sem_level < COUNT_TOP)
                    sem_level++;
                push_outcome(STAT_NO_WAITER, 8'd0, 1'b0);
            end
        end
        else if (mode == MODE_TICK)
        begin
            rem = ticks;
            while (sleeper_ids.size() > 0 && rem > 0)
            begin
                if (sleeper_deltas[0] <= rem)
                begin
                    rem -= sleeper_deltas[0];
                    sleeper_deltas[0] = 0;
                    while (sleeper_ids.size() > 0 && sleeper_deltas[0] == 0)
                    begin
                        if (sem_level < COUNT_TOP)
                            sem_level++;
                        push_outcome(STAT_TIMEOUT, pop_head_sleeper(), 1'b0);
                    end
                end
                else
                begin
                    sleeper_deltas[0] -= rem;
                    rem = 0;
                end
            end
        end
        if (pending_outcomes.size() > before_size)
            pending_outcomes[pending_outcomes.size() - 1].last = 1'b1;
    endfunction

    // Send one word; the prediction is made when it is accepted. The valid
    // stays high after acceptance so words can follow back to back; an idle
    // cycle or draining drops it.
    task automatic send_op(logic [1:0] mode, logic [7:0] tid, logic [15:0] timeout,
                           logic [7:0] ticks);
        while (!quiet_run && $urandom_range(99) < 20)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {ticks, timeout, tid};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_operation(mode, tid, timeout, ticks);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() > 0)
            @(posedge clk);
        // Ticks that expire nothing may still be in flight.
        repeat (80) @(posedge clk);
    endtask

    task automatic load_count(logic [14:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sem_level = value;
        fifo_ids.delete();
        sleeper_ids.delete();
        sleeper_deltas.delete();
    endtask

    // Receiver: random stalls, plus a forced hold-off when requested.
    always @(posedge clk)
    begin
        m_tready <= !hold_off && (quiet_run || $urandom_range(99) >= 20);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t exp_o;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d tdata=%h", $time, m_tuser, m_tdata);
                error_count++;
            end
            else
            begin
                exp_o = pending_outcomes.pop_front();
                if (m_tuser != exp_o.status || m_tdata[7:0] != exp_o.thread
                    || m_tdata[8] != exp_o.rv || m_tdata[24:9] != exp_o.count
                    || m_tdata[31:25] != 7'd0 || m_tlast != exp_o.last)
                begin
                    $display("%0t: mismatch expected st=%0d tid=%0d rv=%0d cnt=%0d last=%0d",
                             $time, exp_o.status, exp_o.thread, exp_o.rv,
                             $signed(exp_o.count), exp_o.last);
                    $display("%0t:          actual   st=%0d tid=%0d rv=%0d cnt=%0d last=%0d",
                             $time, m_tuser, m_tdata[7:0], m_tdata[8],
                             $signed(m_tdata[24:9]), m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Edges of every field, all operations and the special cases.
    task automatic test_directed();
        load_count(15'd2);
        send_op(MODE_WAIT, 8'hFF, 16'hFFFF, 8'd0);
        send_op(MODE_WAIT, 8'h00, 16'h0000, 8'hFF);
        send_op(MODE_WAIT, 8'h11, 16'h0000, 8'd1);
        send_op(MODE_WAIT, 8'h22, 16'd5, 8'd1);
        send_op(MODE_WAIT, 8'h33, 16'd5, 8'd1);
        send_op(MODE_WAIT, 8'h44, 16'd3, 8'd1);
        send_op(MODE_WAIT, 8'h55, 16'hFFFF, 8'd1);
        send_op(MODE_TICK, 8'd0, 16'd0, 8'd0);
        send_op(MODE_TICK, 8'd0, 16'd0, 8'd2);
        send_op(MODE_TICK, 8'd0, 16'd0, 8'd3);
        send_op(MODE_SPARE, 8'hAA, 16'h1234, 8'd9);
        send_op(MODE_SIGNAL, 8'd0, 16'd0, 8'd0);
        send_op(MODE_SIGNAL, 8'd0, 16'd0, 8'd0);
        send_op(MODE_TICK, 8'd0, 16'd0, 8'hFF);
        send_op(MODE_SIGNAL, 8'd0, 16'd0, 8'd0);
        load_count(15'h7FFF);
        send_op(MODE_SIGNAL, 8'd0, 16'd0, 8'd0);
        send_op(MODE_WAIT, 8'h5A, 16'd0, 8'd0);
        send_op(MODE_SIGNAL, 8'd0, 16'd0, 8'd0);
        send_op(MODE_SIGNAL, 8'd0, 16'd0, 8'd0);
    endtask

    // Fill both queues to see rejects, with the receiver held off.
    task automatic test_full_queues();
        load_count(15'd0);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < FIFO_CAP + 1; i++)
                    send_op(MODE_WAIT, 8'(i), 16'd0, 8'd0);
                for (int i = 0; i < SLEEP_CAP + 1; i++)
                    send_op(MODE_WAIT, 8'(8'h80 + i), 16'($urandom_range(1, 4)), 8'd0);
            end
        join
        send_op(MODE_TICK, 8'd0, 16'd0, 8'd2);
        for (int i = 0; i < 18; i++)
            send_op(MODE_SIGNAL, 8'd0, 16'd0, 8'd0);
        send_op(MODE_TICK, 8'd0, 16'd0, 8'hFF);
    endtask

    // Random traffic; half of the waits have short timeouts so sleepers expire.
    task automatic test_random(int n, logic [14:0] start_count);
        int r;
        logic [15:0] tmo;
        load_count(start_count);
        for (int i = 0; i < n; i++)
        begin
            quiet_run = (i >= n / 2 && i < n / 2 + 20);
            r = $urandom_range(99);
            if (r < 45)
            begin
                r = $urandom_range(9);
                tmo = (r < 3) ? 16'd0 : (r < 8) ? 16'($urandom_range(1, 40))
                                                 : 16'($urandom);
                send_op(MODE_WAIT, 8'($urandom), tmo, 8'($urandom));
            end
            else if (r < 70)
                send_op(MODE_SIGNAL, 8'($urandom), 16'($urandom), 8'($urandom));
            else if (r < 97)
                send_op(MODE_TICK, 8'($urandom), 16'($urandom),
                        ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12)));
            else
                send_op(MODE_SPARE, 8'($urandom), 16'($urandom), 8'($urandom));
        end
        quiet_run = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        sem_level = 0;
        @(posedge clk);
        test_directed();
        test_full_queues();
        test_random(40, 15'd0);
        test_random(35, 15'd3);
        drain_results();
        if (error_count == 0)
            $display("tb_timed_counting_semaphore: clean");
        else
            $display("tb_timed_counting_semaphore: errors");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("tb_timed_counting_semaphore: errors");
        $finish;
    end

endmodule

FILE: files.f
src/tcs_pkg.sv
src/tcs_ram.sv
src/timed_counting_semaphore.sv
tb/sv/tb_timed_counting_semaphore.sv
